### rtl/ray_sphere_distance_macros.svh
// ----------------------------------------------------------------------------
// Ray to sphere distance: assertion macros
// Clocked assertions on i_clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_DISTANCE_MACROS_SVH
`define RAY_SPHERE_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
`define RSD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ray_sphere_distance: assertion failed");
`define RSD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ray_sphere_distance: reset assertion failed");
`else
`define RSD_ASSERT(lbl, prop)
`define RSD_ASSERT_RST(lbl, prop)
`endif

`endif

### rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// Ray to sphere distance: shared package
// Widths, configuration register indexes and the square root sideband.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int QW     = 84;   // discriminant word, Q.54
    localparam int SW     = QW/2; // root width
    localparam int RW     = SW+3; // partial remainder width
    localparam int HW     = 42;   // dot product width, Q.27
    localparam int DW     = 24;   // distance width

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS_SQ = 2'd3;

    localparam logic [47:0] RADIUS_SQ_RESET = 48'd16777216;

    typedef struct packed {
        logic signed [HW-1:0] h;
        logic                 c_neg;
        logic                 c_zero;
        logic                 disc_pos;
    } t_side;

endpackage

### rtl/ray_sphere_distance.sv
// ----------------------------------------------------------------------------
// Ray to sphere distance
// Takes one ray per cycle, unless stalled (start point Q12.12, direction Q1.15)
// and returns the nearest non-negative distance to the configured sphere in
// Q12.12, with a hit flag and an inside flag. The pipeline accepts a new ray
// every cycle while the output is not stalled; most of its depth is the
// 42-stage square root, one root bit per stage. Stalls collapse bubbles stage
// by stage, so empty stages keep taking rays while a result waits. Write the
// center and squared radius only while no ray is in flight.
// ----------------------------------------------------------------------------
`include "ray_sphere_distance_macros.svh"

module ray_sphere_distance (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x[23:0] pos_y[47:24] pos_z[71:48] dir_x[87:72] dir_y[103:88] dir_z[119:104]
    input  logic [119:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit[0] hit_distance[24:1] point_inside[25], zero [31:26]
    output logic [31:0]  o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);

    localparam int NPRE = 7;
    localparam int NST  = NPRE + rsd_pkg::SW + 1;
    localparam int OUT  = NST - 1;

    logic signed [23:0] r_cx, r_cy, r_cz;
    logic [47:0]        r_rsq;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    // configuration
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rsq <= rsd_pkg::RADIUS_SQ_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsd_pkg::CFG_CENTER_X:  r_cx  <= i_cfg_data[23:0];
                rsd_pkg::CFG_CENTER_Y:  r_cy  <= i_cfg_data[23:0];
                rsd_pkg::CFG_CENTER_Z:  r_cz  <= i_cfg_data[23:0];
                rsd_pkg::CFG_RADIUS_SQ: r_rsq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when empty or when its successor advances
    always_comb begin
        w_en[OUT] = !r_v[OUT] || i_m_tready;
        for (int k = OUT - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end
    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_v[OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_s_tvalid;
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: offsets from the center
    logic signed [24:0] r0_dx, r0_dy, r0_dz;
    logic signed [15:0] r0_ux, r0_uy, r0_uz;
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_dx <= $signed({i_s_tdata[23], i_s_tdata[23:0]}) - $signed({r_cx[23], r_cx});
            r0_dy <= $signed({i_s_tdata[47], i_s_tdata[47:24]}) - $signed({r_cy[23], r_cy});
            r0_dz <= $signed({i_s_tdata[71], i_s_tdata[71:48]}) - $signed({r_cz[23], r_cz});
            r0_ux <= i_s_tdata[87:72];
            r0_uy <= i_s_tdata[103:88];
            r0_uz <= i_s_tdata[119:104];
        end
    end

    // stage 1: squares and direction products
    logic [49:0]        r1_sx, r1_sy, r1_sz;
    logic signed [40:0] r1_hx, r1_hy, r1_hz;
    logic signed [49:0] w_sx, w_sy, w_sz;
    assign w_sx = r0_dx * r0_dx;
    assign w_sy = r0_dy * r0_dy;
    assign w_sz = r0_dz * r0_dz;
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_sx <= $unsigned(w_sx);
            r1_sy <= $unsigned(w_sy);
            r1_sz <= $unsigned(w_sz);
            r1_hx <= r0_dx * r0_ux;
            r1_hy <= r0_dy * r0_uy;
            r1_hz <= r0_dz * r0_uz;
        end
    end

    // stage 2: sums
    logic [51:0]                   r2_sum;
    logic signed [rsd_pkg::HW-1:0] r2_h;
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_sum <= {2'b0, r1_sx} + {2'b0, r1_sy} + {2'b0, r1_sz};
            r2_h   <= {r1_hx[40], r1_hx} + {r1_hy[40], r1_hy} + {r1_hz[40], r1_hz};
        end
    end

    // stage 3: surface function and |h|
    logic signed [52:0]            r3_c;
    logic [40:0]                   r3_habs;
    logic signed [rsd_pkg::HW-1:0] r3_h;
    logic [rsd_pkg::HW-1:0]        w_hneg;
    assign w_hneg = $unsigned(-r2_h);
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_c    <= $signed({1'b0, r2_sum}) - $signed({5'b0, r_rsq});
            r3_habs <= r2_h[rsd_pkg::HW-1] ? w_hneg[40:0] : r2_h[40:0];
            r3_h    <= r2_h;
        end
    end

    // stage 4: partial products of h*h, |c|
    logic [39:0]                   r4_phh;
    logic [40:0]                   r4_phl;
    logic [41:0]                   r4_pll;
    logic [51:0]                   r4_cabs;
    logic                          r4_cneg, r4_czero;
    logic signed [rsd_pkg::HW-1:0] r4_h;
    logic [52:0]                   w_cneg;
    assign w_cneg = $unsigned(-r3_c);
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_phh   <= r3_habs[40:21] * r3_habs[40:21];
            r4_phl   <= r3_habs[40:21] * r3_habs[20:0];
            r4_pll   <= r3_habs[20:0] * r3_habs[20:0];
            r4_cabs  <= r3_c[52] ? w_cneg[51:0] : r3_c[51:0];
            r4_cneg  <= r3_c[52];
            r4_czero <= (r3_c == '0);
            r4_h     <= r3_h;
        end
    end

    // stage 5: h*h and c scaled to the same point
    logic [rsd_pkg::QW-1:0]        r5_hh, r5_cc;
    logic                          r5_cneg, r5_czero;
    logic signed [rsd_pkg::HW-1:0] r5_h;
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_hh    <= {2'b0, r4_phh, 42'b0} + {21'b0, r4_phl, 22'b0} + {42'b0, r4_pll};
            r5_cc    <= {2'b0, r4_cabs, 30'b0};
            r5_cneg  <= r4_cneg;
            r5_czero <= r4_czero;
            r5_h     <= r4_h;
        end
    end

    // stage 6: discriminant
    logic [rsd_pkg::QW-1:0] r6_q;
    rsd_pkg::t_side         r6_side;
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_side.h      <= r5_h;
            r6_side.c_neg  <= r5_cneg;
            r6_side.c_zero <= r5_czero;
            priority if (r5_cneg) begin
                r6_q             <= r5_hh + r5_cc;
                r6_side.disc_pos <= 1'b1;
            end else if (r5_hh <= r5_cc) begin
                r6_q             <= r5_hh;
                r6_side.disc_pos <= 1'b0;
            end else begin
                r6_q             <= r5_hh - r5_cc;
                r6_side.disc_pos <= 1'b1;
            end
        end
    end

    logic [rsd_pkg::SW-1:0] w_root;
    logic                   w_exact;
    rsd_pkg::t_side         w_side;

    rsd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_en    (w_en[NPRE + rsd_pkg::SW - 1 : NPRE]),
        .i_q     (r6_q),
        .i_side  (r6_side),
        .o_root  (w_root),
        .o_exact (w_exact),
        .o_side  (w_side)
    );

    // output stage: pick the root and range check
    logic signed [43:0] w_nh, w_num;
    logic [43:0]        w_s;
    logic               w_near, w_far, w_fit;
    logic               r_hit, r_inside;
    logic [rsd_pkg::DW-1:0] r_dist;

    assign w_nh   = -{{2{w_side.h[rsd_pkg::HW-1]}}, w_side.h};
    assign w_s    = {2'b0, w_root};
    assign w_near = !(w_side.h > 0) && !w_side.c_neg;
    assign w_far  = !(w_side.h > 0) || w_side.c_neg || w_side.c_zero;
    always_comb begin
        if (w_near) w_num = w_nh - $signed(w_s) - $signed({43'b0, !w_exact});
        else        w_num = w_nh + $signed(w_s);
    end
    assign w_fit = (w_num[43:39] == '0);

    always_ff @(posedge i_clk) begin
        if (w_en[OUT]) begin
            r_inside <= w_side.c_neg;
            if (w_side.disc_pos && (w_near || w_far) && w_fit) begin
                r_hit  <= 1'b1;
                r_dist <= w_num[38:15];
            end else begin
                r_hit  <= 1'b0;
                r_dist <= '1;
            end
        end
    end

    assign o_m_tdata = {6'b0, r_inside, r_dist, r_hit};

    `RSD_ASSERT(a_miss_all_ones, o_m_tvalid && !r_hit |-> r_dist == '1)
    `RSD_ASSERT(a_accept_fills, i_s_tvalid && o_s_tready |=> r_v[0])
    `RSD_ASSERT(a_hold_full, r_v[OUT] && !i_m_tready |=> r_v[OUT] && $stable(r_dist))
    `RSD_ASSERT_RST(a_reset_clears, $past(!i_rst_n) |-> r_v == '0)

endmodule

### rtl/rsd_isqrt.sv
// ----------------------------------------------------------------------------
// Ray to sphere distance: pipelined integer square root
// One result bit per stage, restoring method; reports floor root and exactness.
// ----------------------------------------------------------------------------
module rsd_isqrt (
    input  logic                       i_clk,
    input  logic [rsd_pkg::SW-1:0]     i_en,
    input  logic [rsd_pkg::QW-1:0]     i_q,
    input  rsd_pkg::t_side             i_side,
    output logic [rsd_pkg::SW-1:0]     o_root,
    output logic                       o_exact,
    output rsd_pkg::t_side             o_side
);

    logic [rsd_pkg::RW-1:0] r_rem  [rsd_pkg::SW];
    logic [rsd_pkg::SW-1:0] r_root [rsd_pkg::SW];
    logic [rsd_pkg::QW-1:0] r_q    [rsd_pkg::SW];
    rsd_pkg::t_side         r_side [rsd_pkg::SW];

    for (genvar i = 0; i < rsd_pkg::SW; i++) begin : g_stage
        logic [rsd_pkg::RW-1:0] w_rem_in;
        logic [rsd_pkg::SW-1:0] w_root_in;
        logic [rsd_pkg::QW-1:0] w_q_in;
        rsd_pkg::t_side         w_side_in;
        logic [rsd_pkg::RW-1:0] w_cur;
        logic [rsd_pkg::RW-1:0] w_trial;
        logic [rsd_pkg::RW-1:0] n_rem;
        logic [rsd_pkg::SW-1:0] n_root;

        if (i == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_q_in    = i_q;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[i-1];
            assign w_root_in = r_root[i-1];
            assign w_q_in    = r_q[i-1];
            assign w_side_in = r_side[i-1];
        end

        // bring down the next two bits of the radicand
        assign w_cur   = {w_rem_in[rsd_pkg::RW-3:0],
                          w_q_in[2*(rsd_pkg::SW-1-i)+1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};

        always_comb begin
            if (w_cur >= w_trial) begin
                n_rem  = w_cur - w_trial;
                n_root = {w_root_in[rsd_pkg::SW-2:0], 1'b1};
            end else begin
                n_rem  = w_cur;
                n_root = {w_root_in[rsd_pkg::SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_rem[i]  <= n_rem;
                r_root[i] <= n_root;
                r_q[i]    <= w_q_in;
                r_side[i] <= w_side_in;
            end
        end
    end

    assign o_root  = r_root[rsd_pkg::SW-1];
    assign o_exact = (r_rem[rsd_pkg::SW-1] == '0);
    assign o_side  = r_side[rsd_pkg::SW-1];

endmodule
